// ===== rtl/core/hphd_pkg.sv =====
// ---------------------------------------------------------------------------
// HPACK Huffman decoder package
// Canonical code limits, per-length bases and the rank-to-symbol table.
// ---------------------------------------------------------------------------
package hphd_pkg;

  localparam int SymbolCount = 256;
  localparam int MaxCodeBits = 30;

  typedef struct packed {
    logic [7:0] idx;
    logic       valid;
    logic       bad;
  } hphd_evt_t;

  // Exclusive upper bound of the codes of one length; zero for unused lengths.
  function automatic logic [29:0] code_limit(input logic [4:0] len);
    logic [29:0] lim;
    unique case (len)
      5'd5:    lim = 30'h0a;
      5'd6:    lim = 30'h2e;
      5'd7:    lim = 30'h7c;
      5'd8:    lim = 30'hfe;
      5'd10:   lim = 30'h3fd;
      5'd11:   lim = 30'h7fd;
      5'd12:   lim = 30'hffc;
      5'd13:   lim = 30'h1ffe;
      5'd14:   lim = 30'h3ffe;
      5'd15:   lim = 30'h7fff;
      5'd19:   lim = 30'h7fff3;
      5'd20:   lim = 30'hfffee;
      5'd21:   lim = 30'h1fffe9;
      5'd22:   lim = 30'h3fffec;
      5'd23:   lim = 30'h7ffff5;
      5'd24:   lim = 30'hfffff6;
      5'd25:   lim = 30'h1fffff0;
      5'd26:   lim = 30'h3ffffef;
      5'd27:   lim = 30'h7fffff1;
      5'd28:   lim = 30'hfffffff;
      5'd30:   lim = 30'h3fffffff;
      default: lim = 30'h0;
    endcase
    return lim;
  endfunction

  // Low byte of the first code of one length.
  function automatic logic [7:0] code_first_lo(input logic [4:0] len);
    logic [7:0] f;
    unique case (len)
      5'd6:    f = 8'h14;
      5'd7:    f = 8'h5c;
      5'd8:    f = 8'hf8;
      5'd10:   f = 8'hf8;
      5'd11:   f = 8'hfa;
      5'd12:   f = 8'hfa;
      5'd13:   f = 8'hf8;
      5'd14:   f = 8'hfc;
      5'd15:   f = 8'hfc;
      5'd19:   f = 8'hf0;
      5'd20:   f = 8'he6;
      5'd21:   f = 8'hdc;
      5'd22:   f = 8'hd2;
      5'd23:   f = 8'hd8;
      5'd24:   f = 8'hea;
      5'd25:   f = 8'hec;
      5'd26:   f = 8'he0;
      5'd27:   f = 8'hde;
      5'd28:   f = 8'he2;
      5'd30:   f = 8'hfc;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

  // Rank of the first symbol of one length in the canonical order.
  function automatic logic [7:0] rank_base(input logic [4:0] len);
    logic [7:0] r;
    unique case (len)
      5'd6:    r = 8'd10;
      5'd7:    r = 8'd36;
      5'd8:    r = 8'd68;
      5'd10:   r = 8'd74;
      5'd11:   r = 8'd79;
      5'd12:   r = 8'd82;
      5'd13:   r = 8'd84;
      5'd14:   r = 8'd90;
      5'd15:   r = 8'd92;
      5'd19:   r = 8'd95;
      5'd20:   r = 8'd98;
      5'd21:   r = 8'd106;
      5'd22:   r = 8'd119;
      5'd23:   r = 8'd145;
      5'd24:   r = 8'd174;
      5'd25:   r = 8'd186;
      5'd26:   r = 8'd190;
      5'd27:   r = 8'd205;
      5'd28:   r = 8'd224;
      5'd30:   r = 8'd253;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  localparam logic [7:0] RankSym [SymbolCount] = '{
    8'd48, 8'd49, 8'd50, 8'd97, 8'd99, 8'd101, 8'd105, 8'd111, 8'd115, 8'd116,
    8'd32, 8'd37, 8'd45, 8'd46, 8'd47, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55,
    8'd56, 8'd57, 8'd61, 8'd65, 8'd95, 8'd98, 8'd100, 8'd102, 8'd103, 8'd104,
    8'd108, 8'd109, 8'd110, 8'd112, 8'd114, 8'd117,
    8'd58, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74,
    8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84,
    8'd85, 8'd86, 8'd87, 8'd89, 8'd106, 8'd107, 8'd113, 8'd118, 8'd119, 8'd120,
    8'd121, 8'd122,
    8'd38, 8'd42, 8'd44, 8'd59, 8'd88, 8'd90,
    8'd33, 8'd34, 8'd40, 8'd41, 8'd63,
    8'd39, 8'd43, 8'd124,
    8'd35, 8'd62,
    8'd0, 8'd36, 8'd64, 8'd91, 8'd93, 8'd126,
    8'd94, 8'd125,
    8'd60, 8'd96, 8'd123,
    8'd92, 8'd195, 8'd208,
    8'd128, 8'd130, 8'd131, 8'd162, 8'd184, 8'd194, 8'd224, 8'd226,
    8'd153, 8'd161, 8'd167, 8'd172, 8'd176, 8'd177, 8'd179, 8'd209, 8'd216,
    8'd217, 8'd227, 8'd229, 8'd230,
    8'd129, 8'd132, 8'd133, 8'd134, 8'd136, 8'd146, 8'd154, 8'd156, 8'd160,
    8'd163, 8'd164, 8'd169, 8'd170, 8'd173, 8'd178, 8'd181, 8'd185, 8'd186,
    8'd187, 8'd189, 8'd190, 8'd196, 8'd198, 8'd228, 8'd232, 8'd233,
    8'd1, 8'd135, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd143, 8'd147,
    8'd149, 8'd150, 8'd151, 8'd152, 8'd155, 8'd157, 8'd158, 8'd165, 8'd166,
    8'd168, 8'd174, 8'd175, 8'd180, 8'd182, 8'd183, 8'd188, 8'd191, 8'd197,
    8'd231, 8'd239,
    8'd9, 8'd142, 8'd144, 8'd145, 8'd148, 8'd159, 8'd171, 8'd206, 8'd215,
    8'd225, 8'd236, 8'd237,
    8'd199, 8'd207, 8'd234, 8'd235,
    8'd192, 8'd193, 8'd200, 8'd201, 8'd202, 8'd205, 8'd210, 8'd213, 8'd218,
    8'd219, 8'd238, 8'd240, 8'd242, 8'd243, 8'd255,
    8'd203, 8'd204, 8'd211, 8'd212, 8'd214, 8'd221, 8'd222, 8'd223, 8'd241,
    8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd250, 8'd251, 8'd252, 8'd253,
    8'd254,
    8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd11, 8'd12, 8'd14, 8'd15,
    8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd23, 8'd24, 8'd25, 8'd26,
    8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd127, 8'd220, 8'd249,
    8'd10, 8'd13, 8'd22
  };

endpackage

// ===== rtl/core/hpack_huffman_decoder_top.sv =====
// A byte goes through the input, result pair and output registers in that order.
// Throughput: one result per cycle while not stalled, so one byte per cycle
// if it completes at most one symbol; a byte with two waits for both results.
// The result pair register and the output register set that rate.
// Reset clears the pending code, its length and all valid flags at once.
// ---------------------------------------------------------------------------
// HPACK Huffman decoder top level
// Decodes one coded byte per beat against the canonical code table.
// ---------------------------------------------------------------------------
module hpack_huffman_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] code_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] symbol_o,
  output logic       symbol_valid_o,
  output logic       last_of_byte_o,
  output logic       bad_code_o,
  output logic [4:0] leftover_bits_o
);
  import hphd_pkg::*;

  logic        in_vq;
  logic [7:0]  in_byte_q;
  logic        in_eos_q;
  logic [29:0] part_q, part_d;
  logic [4:0]  plen_q, plen_d;

  logic        p_vq, p_two_q, p_sel_q;
  hphd_evt_t   p_ent_q [2];
  hphd_evt_t   ent0_d, ent1_d;
  logic        two_d;
  logic [4:0]  p_left_q;

  logic        o_vq;
  logic [7:0]  sym_q;
  logic        symv_q, last_q, bad_q;
  logic [4:0]  left_q;

  logic        o_free, p_move, p_free, p_load, in_acc;
  hphd_evt_t   cur_ent;

  assign o_free     = !o_vq || !out_stall_i;
  assign p_move     = p_vq && o_free;
  assign p_free     = !p_vq || (p_move && (p_sel_q == p_two_q));
  assign p_load     = in_vq && p_free;
  assign in_stall_o = in_vq && !p_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign cur_ent    = p_ent_q[p_sel_q];

  always_comb begin
    logic [37:0] wide;
    logic [37:0] sh;
    logic [29:0] cand;
    logic [5:0]  lenk;
    logic        ev1, hit1, ev2;
    logic [3:0]  k1, j2, cons;
    logic [29:0] c1;
    logic [4:0]  l1;
    logic [7:0]  rem, code2, c2, mask;
    logic [3:0]  remlen;
    wide = {part_q, in_byte_q};
    ev1 = 1'b0; hit1 = 1'b0; k1 = 4'd0; c1 = '0; l1 = '0;
    for (int k = 8; k >= 1; k--) begin
      sh   = wide >> (8 - k);
      cand = sh[29:0];
      lenk = {1'b0, plen_q} + 6'(k);
      if (lenk <= 6'(MaxCodeBits)) begin
        if (cand < code_limit(lenk[4:0])) begin
          ev1 = 1'b1; hit1 = 1'b1; k1 = 4'(k); c1 = cand; l1 = lenk[4:0];
        end else if (lenk == 6'(MaxCodeBits)) begin
          ev1 = 1'b1; hit1 = 1'b0; k1 = 4'(k); c1 = cand; l1 = lenk[4:0];
        end
      end
    end
    rem    = in_byte_q << k1;
    remlen = 4'd8 - k1;
    ev2 = 1'b0; j2 = 4'd0; c2 = '0;
    for (int j = 7; j >= 5; j--) begin
      code2 = rem >> (8 - j);
      if (ev1 && (4'(j) <= remlen) && ({22'd0, code2} < code_limit(5'(j)))) begin
        ev2 = 1'b1; j2 = 4'(j); c2 = code2;
      end
    end
    cons = ev2 ? (k1 + j2) : k1;
    mask = 8'hff >> cons;
    if (!ev1) begin
      part_d = wide[29:0];
      plen_d = plen_q + 5'd8;
    end else begin
      part_d = {22'd0, in_byte_q & mask};
      plen_d = {1'b0, 4'd8 - cons};
    end
    ent0_d.idx   = rank_base(l1) + c1[7:0] - code_first_lo(l1);
    ent0_d.valid = hit1;
    ent0_d.bad   = ev1 && !hit1;
    ent1_d.idx   = rank_base({1'b0, j2}) + c2 - code_first_lo({1'b0, j2});
    ent1_d.valid = 1'b1;
    ent1_d.bad   = 1'b0;
    two_d        = ev2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq   <= 1'b0;
      part_q  <= '0;
      plen_q  <= '0;
      p_vq    <= 1'b0;
      p_sel_q <= 1'b0;
      o_vq    <= 1'b0;
    end else begin
      if (in_acc) begin
        in_vq <= 1'b1;
      end else if (p_load) begin
        in_vq <= 1'b0;
      end
      if (p_load) begin
        part_q  <= in_eos_q ? '0 : part_d;
        plen_q  <= in_eos_q ? '0 : plen_d;
        p_vq    <= 1'b1;
        p_sel_q <= 1'b0;
      end else if (p_move) begin
        if (p_sel_q == p_two_q) begin
          p_vq <= 1'b0;
        end else begin
          p_sel_q <= 1'b1;
        end
      end
      if (p_move) begin
        o_vq <= 1'b1;
      end else if (!out_stall_i) begin
        o_vq <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= code_byte_i;
      in_eos_q  <= end_of_string_i;
    end
    if (p_load) begin
      p_ent_q[0] <= ent0_d;
      p_ent_q[1] <= ent1_d;
      p_two_q    <= two_d;
      p_left_q   <= plen_d;
    end
    if (p_move) begin
      sym_q  <= cur_ent.valid ? RankSym[cur_ent.idx] : 8'd0;
      symv_q <= cur_ent.valid;
      bad_q  <= cur_ent.bad;
      last_q <= (p_sel_q == p_two_q);
      left_q <= p_left_q;
    end
  end

  assign out_valid_o     = o_vq;
  assign symbol_o        = sym_q;
  assign symbol_valid_o  = symv_q;
  assign last_of_byte_o  = last_q;
  assign bad_code_o      = bad_q;
  assign leftover_bits_o = left_q;

endmodule

// ===== rtl/core/hphd_checker.sv =====
// ---------------------------------------------------------------------------
// HPACK Huffman decoder port checker
// Watches the top-level ports of the decoder over time.
// ---------------------------------------------------------------------------
module hphd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] symbol_o,
  input logic       symbol_valid_o,
  input logic       bad_code_o,
  input logic [4:0] leftover_bits_o
);

  // A stalled result beat holds its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(symbol_o)
      && $stable(leftover_bits_o))
    else $error("stalled result beat changed");

  // A result never carries a symbol and an invalid code at once.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(symbol_valid_o && bad_code_o))
    else $error("symbol and bad code together");

  // A beat without a symbol reports symbol zero.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !symbol_valid_o |-> symbol_o == 8'd0)
    else $error("nonzero symbol without symbol_valid");

  // No more than twenty-nine bits can stay pending.
  a_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> leftover_bits_o <= 5'd29)
    else $error("leftover bit count out of range");

endmodule

bind hpack_huffman_decoder_top hphd_checker u_hphd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .symbol_o        (symbol_o),
  .symbol_valid_o  (symbol_valid_o),
  .bad_code_o      (bad_code_o),
  .leftover_bits_o (leftover_bits_o)
);
